@@ design/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the set-associative cache model
// Field widths, register indexes, the line record and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  // default geometry
  localparam int unsigned SALC_MAX_SET_BITS = 6;
  localparam int unsigned SALC_MAX_WAYS     = 8;

  // field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned AGE_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // configuration register widths and reset values
  localparam int unsigned SET_BITS_W    = 3;
  localparam int unsigned OFFSET_BITS_W = 6;
  localparam int unsigned WAYS_W        = 4;
  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]        WAYS_RST        = 4'd1;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  // one cache line record
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_SCAN,
    S_COMMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic load_item;
    logic read;
    logic cmp;
    logic scan_step;
    logic commit;
    logic last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ design/salc_req_if.sv @@
// ----------------------------------------------------------------------------
// salc_req_if: access request channel
// Valid/ready handshake carrying command and byte address.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_req_if;
  import salc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

`default_nettype wire

@@ design/salc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// salc_rsp_if: lookup result channel
// Valid/ready handshake carrying per-lookup flags and running totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_rsp_if;
  import salc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic             last;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;

  modport source (output valid, output hit, output evicted, output last,
                  output hit_total, output miss_total, output eviction_total,
                  input ready);
  modport sink   (input valid, input hit, input evicted, input last,
                  input hit_total, input miss_total, input eviction_total,
                  output ready);
endinterface

`default_nettype wire

@@ design/salc_ram.sv @@
// ----------------------------------------------------------------------------
// salc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/salc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salc_ctrl: sequencing state machine
// Runs the clearing pass, takes requests and steps each lookup through
// read, compare, victim scan and commit; modify runs two lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire salc_pkg::cmd_e    in_cmd_i,
  output logic                   in_ready_o,
  output salc_pkg::dp_cmd_t      dp_cmd_o,
  input  wire salc_pkg::dp_sts_t dp_sts_i
);
  import salc_pkg::*;

  state_e state_q, state_d;
  logic   two_q, two_d;     // request needs two lookups
  logic   pass2_q, pass2_d; // second lookup in progress

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      two_q   <= 1'b0;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      two_q   <= two_d;
      pass2_q <= pass2_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    two_d      = two_q;
    pass2_d    = pass2_q;
    in_ready_o = 1'b0;
    dp_cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        dp_cmd_o.clear = 1'b1;
        if (dp_sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.load_item = 1'b1;
          pass2_d            = 1'b0;
          case (in_cmd_i)
            CMD_LOAD, CMD_STORE: begin
              two_d   = 1'b0;
              state_d = S_READ;
            end
            CMD_MODIFY: begin
              two_d   = 1'b1;
              state_d = S_READ;
            end
            default: ; // unused command: no lookup, no result
          endcase
        end
      end
      S_READ: begin
        dp_cmd_o.read = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        dp_cmd_o.cmp = 1'b1;
        state_d      = dp_sts_i.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        if (dp_sts_i.scan_done) begin
          state_d = S_COMMIT;
        end else begin
          dp_cmd_o.scan_step = 1'b1;
        end
      end
      S_COMMIT: begin
        dp_cmd_o.last = !(two_q && !pass2_q);
        if (dp_sts_i.out_free) begin
          dp_cmd_o.commit = 1'b1;
          if (two_q && !pass2_q) begin
            pass2_d = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/salc_dp.sv @@
// ----------------------------------------------------------------------------
// salc_dp: cache datapath
// Config registers, address split, line RAM, tag compare and aging,
// victim scan, totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_dp #(
  parameter int unsigned MaxSetBits = salc_pkg::SALC_MAX_SET_BITS,
  parameter int unsigned MaxWays    = salc_pkg::SALC_MAX_WAYS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request payload
  input  wire logic [salc_pkg::ADDR_W-1:0]         address_i,
  // controller
  input  wire salc_pkg::dp_cmd_t                   dp_cmd_i,
  output salc_pkg::dp_sts_t                        dp_sts_o,
  // result
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     hit_o,
  output logic                                     evicted_o,
  output logic                                     last_o,
  output logic [salc_pkg::CNT_W-1:0]               hit_total_o,
  output logic [salc_pkg::CNT_W-1:0]               miss_total_o,
  output logic [salc_pkg::CNT_W-1:0]               eviction_total_o
);
  import salc_pkg::*;

  localparam int unsigned SetW    = MaxSetBits;
  localparam int unsigned Depth   = 1 << MaxSetBits;
  localparam int unsigned SbW     = 4;                  // holds 0..15
  localparam int unsigned CmpW    = 6;                  // holds 0..63
  localparam int unsigned WayCntW = $clog2(MaxWays + 1);
  localparam int unsigned WayIdxW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned RowW    = MaxWays * $bits(line_t);

  // ---------------- configuration registers ----------------
  logic [SET_BITS_W-1:0]    set_bits_q;
  logic [OFFSET_BITS_W-1:0] offset_bits_q;
  logic [WAYS_W-1:0]        ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      offset_bits_q <= OFFSET_BITS_RST;
      ways_q        <= WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SET_BITS:    set_bits_q    <= cfg_data_i[SET_BITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[OFFSET_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_q        <= cfg_data_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective set bits and way count
  logic [SbW-1:0]  sb_eff;
  logic [CmpW-1:0] ways_eff;
  logic [MaxWays-1:0] in_use;

  always_comb begin
    sb_eff = SbW'(set_bits_q);
    if (sb_eff > SbW'(MaxSetBits)) begin
      sb_eff = SbW'(MaxSetBits);
    end
    ways_eff = CmpW'(ways_q);
    if (ways_eff == '0) begin
      ways_eff = CmpW'(1);
    end else if (ways_eff > CmpW'(MaxWays)) begin
      ways_eff = CmpW'(MaxWays);
    end
    for (int w = 0; w < MaxWays; w++) begin
      in_use[w] = CmpW'(w) < ways_eff;
    end
  end

  // ---------------- request latch and address split ----------------
  logic [ADDR_W-1:0] addr_q;
  logic [SetW-1:0]   set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [ADDR_W-1:0] above;
  logic [ADDR_W-1:0] tag_full;
  logic [SetW-1:0]   set_mask;
  logic [SetW-1:0]   set_idx;

  always_comb begin
    above    = addr_q >> offset_bits_q;
    tag_full = above >> sb_eff;
    for (int i = 0; i < SetW; i++) begin
      set_mask[i] = SbW'(i) < sb_eff;
    end
    set_idx = above[SetW-1:0] & set_mask;
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_item) begin
      addr_q <= address_i;
    end
    if (dp_cmd_i.read) begin
      set_q <= set_idx;
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  // ---------------- line RAM, one row per set ----------------
  logic [SetW-1:0] clr_cnt_q;
  logic [RowW-1:0] ram_rdata;
  logic [RowW-1:0] ram_wdata;
  logic [SetW-1:0] ram_waddr;
  line_t [MaxWays-1:0] rd_row;
  line_t [MaxWays-1:0] row_q;
  line_t [MaxWays-1:0] new_row;

  assign rd_row    = ram_rdata;
  assign ram_waddr = dp_cmd_i.clear ? clr_cnt_q : set_q;
  assign ram_wdata = dp_cmd_i.clear ? '0 : new_row;

  salc_ram #(
    .Width (RowW),
    .Depth (Depth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (dp_cmd_i.clear | dp_cmd_i.commit),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (dp_cmd_i.read),
    .raddr_i (set_idx),
    .rdata_o (ram_rdata)
  );

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (dp_cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // ---------------- compare and age ----------------
  line_t [MaxWays-1:0] aged_row;
  logic                hit_c;
  logic                has_free_c;
  logic [WayIdxW-1:0]  free_idx_c;

  always_comb begin
    aged_row   = rd_row;
    hit_c      = 1'b0;
    has_free_c = 1'b0;
    free_idx_c = '0;
    for (int w = 0; w < MaxWays; w++) begin
      if (in_use[w] && rd_row[w].valid) begin
        if (rd_row[w].tag == tag_q) begin
          aged_row[w].age = '0;
          hit_c           = 1'b1;
        end else if (rd_row[w].age != '1) begin
          aged_row[w].age = rd_row[w].age + 1'b1;
        end
      end
    end
    // first free way: scan downward so the lowest one wins
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (in_use[w] && !rd_row[w].valid) begin
        has_free_c = 1'b1;
        free_idx_c = WayIdxW'(w);
      end
    end
  end

  logic               hit_q;
  logic               has_free_q;
  logic [WayIdxW-1:0] free_idx_q;

  // ---------------- victim scan, one way per cycle ----------------
  logic [WayCntW-1:0] scan_cnt_q;
  logic [WayIdxW-1:0] best_idx_q;
  logic [AGE_W-1:0]   best_age_q;
  logic [AGE_W-1:0]   scan_age;

  assign scan_age = row_q[scan_cnt_q[WayIdxW-1:0]].age;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.cmp) begin
      row_q      <= aged_row;
      hit_q      <= hit_c;
      has_free_q <= has_free_c;
      free_idx_q <= free_idx_c;
      scan_cnt_q <= WayCntW'(1);
      best_idx_q <= '0;
      best_age_q <= aged_row[0].age;
    end else if (dp_cmd_i.scan_step) begin
      scan_cnt_q <= scan_cnt_q + 1'b1;
      if (scan_age > best_age_q) begin
        best_age_q <= scan_age;
        best_idx_q <= scan_cnt_q[WayIdxW-1:0];
      end
    end
  end

  // ---------------- commit: fill line, totals, result ----------------
  logic               evict_c;
  logic [WayIdxW-1:0] pick;

  always_comb begin
    evict_c = !hit_q && !has_free_q;
    pick    = has_free_q ? free_idx_q : best_idx_q;
    new_row = row_q;
    if (!hit_q) begin
      new_row[pick].valid = 1'b1;
      new_row[pick].tag   = tag_q;
      new_row[pick].age   = '0;
    end
  end

  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
  logic             out_valid_q;
  logic             out_hit_q, out_evicted_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (dp_cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (hit_q) begin
          hits_q <= hits_q + 1'b1;
        end else begin
          misses_q <= misses_q + 1'b1;
        end
        if (evict_c) begin
          evicts_q <= evicts_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.commit) begin
      out_hit_q     <= hit_q;
      out_evicted_q <= evict_c;
      out_last_q    <= dp_cmd_i.last;
    end
  end

  // totals change only at commit, which waits for a free result slot
  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign evicted_o        = out_evicted_q;
  assign last_o           = out_last_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evicts_q;

  // ---------------- status ----------------
  always_comb begin
    dp_sts_o            = '0;
    dp_sts_o.clear_done = clr_cnt_q == '1;
    dp_sts_o.need_scan  = !hit_c && !has_free_c;
    dp_sts_o.scan_done  = CmpW'(scan_cnt_q) >= ways_eff;
    dp_sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

@@ design/set_assoc_lru_cache_sim_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit: tag-only set-associative cache with LRU ages
// Looks up each access in a 2^MaxSetBits x MaxWays line store and reports
// hit, eviction and running totals per lookup.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        command, address
//   rsp_o    out  valid/ready        hit, evicted, last, three totals
//   cfg      in   cfg_we_i only      cfg_idx_i, cfg_data_i
//
// A lookup steps through RAM read, compare/age and commit after the idle
// state takes the request; modify runs two lookups. A full-set eviction
// adds a victim scan, one way at a time, over the ways in use
// (ways_in_use clamped to 1..MaxWays) through one shared age comparator.
// Commit waits while a result is pending.
// After reset a clearing pass writes 2^MaxSetBits rows before the first
// request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_sim_unit #(
  parameter int unsigned MaxSetBits = salc_pkg::SALC_MAX_SET_BITS,
  parameter int unsigned MaxWays    = salc_pkg::SALC_MAX_WAYS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  salc_req_if.sink                             req_i,
  salc_rsp_if.source                           rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import salc_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  assign req_i.ready = in_ready;

  // sequencer
  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_cmd_i   (cmd_e'(req_i.command)),
    .in_ready_o (in_ready),
    .dp_cmd_o   (dp_cmd),
    .dp_sts_i   (dp_sts)
  );

  // datapath
  salc_dp #(
    .MaxSetBits (MaxSetBits),
    .MaxWays    (MaxWays)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .address_i        (req_i.address),
    .dp_cmd_i         (dp_cmd),
    .dp_sts_o         (dp_sts),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .hit_o            (rsp_o.hit),
    .evicted_o        (rsp_o.evicted),
    .last_o           (rsp_o.last),
    .hit_total_o      (rsp_o.hit_total),
    .miss_total_o     (rsp_o.miss_total),
    .eviction_total_o (rsp_o.eviction_total)
  );

endmodule

`default_nettype wire

@@ sim/set_assoc_lru_cache_sim_unit_test.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit_test: self-checking bench for the LRU tag cache
// Drives access requests through the request channel. A behavioral copy of
// the cache (valid/tag/age per line, running totals) predicts every lookup
// result. Results are compared field by field in arrival order. Geometry is
// reprogrammed between phases. Both channels idle at random, and one phase
// holds off the result side long enough to back up the request side.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit_test;
  import salc_pkg::*;

  localparam int unsigned SETS           = 1 << SALC_MAX_SET_BITS;
  localparam int unsigned WAYS           = SALC_MAX_WAYS;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  // one predicted lookup result
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } lookup_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  salc_req_if req_bus ();
  salc_rsp_if rsp_bus ();

  set_assoc_lru_cache_sim_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // behavioral copy of the line store and geometry
  bit               line_valid [SETS][WAYS];
  bit [TAG_W-1:0]   line_tag   [SETS][WAYS];
  bit [AGE_W-1:0]   line_age   [SETS][WAYS];
  bit [CNT_W-1:0]   hits_exp;
  bit [CNT_W-1:0]   misses_exp;
  bit [CNT_W-1:0]   evict_count;
  logic [SET_BITS_W-1:0]    cur_set_bits    = SET_BITS_RST;
  logic [OFFSET_BITS_W-1:0] cur_offset_bits = OFFSET_BITS_RST;
  logic [WAYS_W-1:0]        cur_ways        = WAYS_RST;

  lookup_res_t pending_lookups[$];
  lookup_res_t expected_res;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned rsp_stall_left;
  int unsigned rsp_run_left;
  bit          idle_en;
  bit          hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // set bits and way count after clamping
  function automatic int unsigned eff_set_bits();
    return (cur_set_bits > SALC_MAX_SET_BITS) ? SALC_MAX_SET_BITS : cur_set_bits;
  endfunction

  function automatic int unsigned eff_ways();
    if (cur_ways == 0) return 1;
    return (cur_ways > WAYS) ? WAYS : cur_ways;
  endfunction

  // one lookup: age the set, then hit or fill/evict
  function automatic lookup_res_t cache_lookup(logic [ADDR_W-1:0] addr, bit is_last);
    int unsigned       sb;
    int unsigned       nways;
    int unsigned       set_idx;
    int unsigned       pick;
    logic [ADDR_W-1:0] above;
    logic [ADDR_W-1:0] above_sh;
    bit [TAG_W-1:0]    tag;
    bit [AGE_W-1:0]    best;
    bit                hit;
    bit                evicted;
    lookup_res_t       r;
    sb       = eff_set_bits();
    nways    = eff_ways();
    above    = addr >> cur_offset_bits;
    set_idx  = int'(above & ((64'd1 << sb) - 64'd1));
    above_sh = above >> sb;
    tag      = above_sh[TAG_W-1:0];
    hit      = 1'b0;
    evicted  = 1'b0;
    for (int w = 0; w < nways; w++) begin
      if (line_valid[set_idx][w]) begin
        // every matching line is refreshed, duplicates included
        if (line_tag[set_idx][w] == tag) begin
          line_age[set_idx][w] = '0;
          hit = 1'b1;
        end else if (line_age[set_idx][w] != '1) begin
          line_age[set_idx][w]++;
        end
      end
    end
    if (hit) begin
      hits_exp++;
    end else begin
      misses_exp++;
      pick = nways;
      for (int w = 0; w < nways; w++) begin
        if (!line_valid[set_idx][w] && pick == nways) pick = w;
      end
      // set full: oldest line goes, lowest way wins a tie
      if (pick == nways) begin
        pick = 0;
        best = line_age[set_idx][0];
        for (int w = 1; w < nways; w++) begin
          if (line_age[set_idx][w] > best) begin
            best = line_age[set_idx][w];
            pick = w;
          end
        end
        evicted = 1'b1;
        evict_count++;
      end
      line_valid[set_idx][pick] = 1'b1;
      line_tag[set_idx][pick]   = tag;
      line_age[set_idx][pick]   = '0;
    end
    r.hit            = hit;
    r.evicted        = evicted;
    r.last           = is_last;
    r.hit_total      = hits_exp;
    r.miss_total     = misses_exp;
    r.eviction_total = evict_count;
    return r;
  endfunction

  // queue the lookups one accepted request causes
  function automatic void predict_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        pending_lookups.push_back(cache_lookup(addr, 1'b1));
      end
      CMD_MODIFY: begin
        pending_lookups.push_back(cache_lookup(addr, 1'b0));
        pending_lookups.push_back(cache_lookup(addr, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  // offer one request, with an optional random gap in front
  task automatic send_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.command <= cmd;
    req_bus.address <= addr;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
    predict_access(cmd, addr);
  endtask

  // stop offering, let every result drain, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // program all three geometry registers while idle
  task automatic apply_config(logic [SET_BITS_W-1:0] sb, logic [OFFSET_BITS_W-1:0] off,
                              logic [WAYS_W-1:0] ways);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SET_BITS;
    cfg_data <= CFG_DATA_W'(sb);
    @(negedge clk);
    cfg_idx  <= CFG_OFFSET_BITS;
    cfg_data <= off;
    @(negedge clk);
    cfg_idx  <= CFG_WAYS_IN_USE;
    cfg_data <= CFG_DATA_W'(ways);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_set_bits    = sb;
    cur_offset_bits = off;
    cur_ways        = ways;
  endtask

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_LOAD;
    if (r < 65) return CMD_STORE;
    if (r < 95) return CMD_MODIFY;
    return CMD_UNUSED;
  endfunction

  // mostly a small tag pool over a few sets so hits and evictions are common;
  // junk above the 32 tag bits checks that the tag is truncated
  function automatic logic [ADDR_W-1:0] make_address(bit [TAG_W-1:0] base_tag);
    int unsigned       sbe;
    logic [ADDR_W-1:0] tag_part;
    logic [ADDR_W-1:0] set_part;
    logic [ADDR_W-1:0] low;
    if ($urandom_range(0, 9) == 0) return {$urandom(), $urandom()};
    sbe      = eff_set_bits();
    tag_part = {$urandom(), base_tag + TAG_W'($urandom_range(0, eff_ways() + 2))};
    set_part = ($urandom_range(0, 3) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 2));
    set_part = set_part & ((64'd1 << sbe) - 64'd1);
    low      = {$urandom(), $urandom()} & ((64'd1 << cur_offset_bits) - 64'd1);
    return (tag_part << (cur_offset_bits + sbe)) | (set_part << cur_offset_bits) | low;
  endfunction

  task automatic run_random_phase(int unsigned n_items, logic [SET_BITS_W-1:0] sb,
                                  logic [OFFSET_BITS_W-1:0] off, logic [WAYS_W-1:0] ways);
    bit [TAG_W-1:0] base_tag;
    apply_config(sb, off, ways);
    base_tag = $urandom();
    repeat (n_items) send_access(pick_command(), make_address(base_tag));
  endtask

  // reset geometry: fill, hit, two-lookup modify, conflict, unused command
  task automatic test_reset_defaults();
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_STORE, 64'h8);
    send_access(CMD_MODIFY, ADDR_ONES);
    send_access(CMD_LOAD, 64'h100);
    send_access(CMD_UNUSED, 64'h0);
    send_access(CMD_LOAD, 64'h0);
  endtask

  // set bits above the maximum, way counts 0 and above the maximum, huge offsets
  task automatic test_config_extremes();
    apply_config(3'd7, 6'd63, 4'd15);
    send_access(CMD_LOAD, ADDR_ONES);
    send_access(CMD_STORE, 64'h0);
    send_access(CMD_MODIFY, 64'h8000_0000_0000_0000);
    send_access(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    apply_config(3'd0, 6'd0, 4'd0);
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_LOAD, ADDR_ONES);
    send_access(CMD_MODIFY, 64'h1);
    apply_config(3'd6, 6'd32, 4'd8);
    send_access(CMD_LOAD, ADDR_ONES);
    send_access(CMD_STORE, 64'h0000_0001_0000_0000);
  endtask

  // same tag in two ways of one set after shrinking and regrowing the way count
  task automatic test_duplicate_tags();
    apply_config(3'd6, 6'd0, 4'd2);
    send_access(CMD_LOAD, (64'd5 << 6) | 64'd62);
    send_access(CMD_LOAD, (64'd9 << 6) | 64'd62);
    apply_config(3'd6, 6'd0, 4'd1);
    send_access(CMD_LOAD, (64'd9 << 6) | 64'd62);
    apply_config(3'd6, 6'd0, 4'd2);
    send_access(CMD_LOAD, (64'd9 << 6) | 64'd62);
    send_access(CMD_STORE, (64'd3 << 6) | 64'd62);
    send_access(CMD_LOAD, (64'd9 << 6) | 64'd62);
  endtask

  // fill a fresh 3-way set and push one more tag in to force a victim scan
  task automatic test_full_set_eviction();
    apply_config(3'd2, 6'd5, 4'd3);
    for (int t = 1; t <= 4; t++) send_access(CMD_LOAD, (64'(t) << 7) | (64'd2 << 5));
    send_access(CMD_MODIFY, (64'd2 << 7) | (64'd2 << 5));
  endtask

  // result side holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    bit [TAG_W-1:0] base_tag;
    apply_config(3'd2, 6'd4, 4'd4);
    base_tag = $urandom();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_access(pick_command(), make_address(base_tag));
    idle_en  = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(145, 3'd4, 6'd4, 4'd1);
    run_random_phase(145, 3'd2, 6'd4, 4'd4);
    run_random_phase(145, 3'd0, 6'd6, 4'd8);
    run_random_phase(145, 3'd6, 6'd0, 4'd8);
    run_random_phase(145, 3'd3, 6'd5, 4'd2);
    run_random_phase(145, 3'd7, 6'd10, 4'd15);
    run_random_phase(145, 3'd1, 6'd3, 4'd0);
    run_random_phase(145, 3'd5, 6'd63, 4'd6);
    run_random_phase(145, 3'd2, 6'd28, 4'd8);
    repeat (3) begin
      run_random_phase(145, SET_BITS_W'($urandom_range(0, 7)),
                       OFFSET_BITS_W'($urandom_range(0, 63)), WAYS_W'($urandom_range(0, 15)));
    end
  endtask

  // final stretch at full rate on both sides
  task automatic test_full_rate_tail();
    idle_en = 1'b0;
    run_random_phase(110, 3'd3, 6'd4, 4'd8);
  endtask

  // stimulus sequence
  initial begin
    rst_n           = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.command = CMD_LOAD;
    req_bus.address = '0;
    rsp_bus.ready   = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_SET_BITS;
    cfg_data        = '0;
    idle_en         = 1'b1;
    hold_req        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_duplicate_tags();
    test_full_set_eviction();
    test_backpressure();
    test_random_traffic();
    test_full_rate_tail();
    wait_idle();

    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("PASS set_assoc_lru_cache_sim_unit");
    end else begin
      $display("FAIL set_assoc_lru_cache_sim_unit");
    end
    $finish;
  end

  // result side ready: random stall bursts, run stretches, one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req       = 1'b0;
      rsp_stall_left = HOLD_CYCLES - 1;
      rsp_run_left   = 0;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_stall_left != 0) begin
      rsp_stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_run_left != 0) begin
      rsp_run_left--;
      rsp_bus.ready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 2) == 0) begin
      rsp_stall_left = $urandom_range(1, 17) - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_run_left = $urandom_range(1, 40) - 1;
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_lookups.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result hit=%0b evicted=%0b last=%0b totals %0d/%0d/%0d",
                 $time, rsp_bus.hit, rsp_bus.evicted, rsp_bus.last, rsp_bus.hit_total,
                 rsp_bus.miss_total, rsp_bus.eviction_total);
      end else begin
        expected_res = pending_lookups.pop_front();
        check_field("hit", CNT_W'(expected_res.hit), CNT_W'(rsp_bus.hit));
        check_field("evicted", CNT_W'(expected_res.evicted), CNT_W'(rsp_bus.evicted));
        check_field("last", CNT_W'(expected_res.last), CNT_W'(rsp_bus.last));
        check_field("hit_total", expected_res.hit_total, rsp_bus.hit_total);
        check_field("miss_total", expected_res.miss_total, rsp_bus.miss_total);
        check_field("eviction_total", expected_res.eviction_total, rsp_bus.eviction_total);
      end
    end

    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL set_assoc_lru_cache_sim_unit");
      $finish;
    end
  end

endmodule
